// File: rtl/lsc_pkg.sv
// lsc_pkg: shared types, constants and helpers of the subboundary classifier
// used by every rtl file of the block; depends on nothing

package lsc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned EXT_W       = 64;
  localparam int unsigned TOL_W       = 32;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned FLAG_W      = 8;
  localparam int unsigned CODE_W      = 6;
  localparam int unsigned CMP_W       = ((VALUE_WIDTH > TOL_W) ? VALUE_WIDTH : TOL_W) + 1;

  localparam logic [OP_W-1:0] CASE_1 = 4'd1;
  localparam logic [OP_W-1:0] CASE_2 = 4'd2;
  localparam logic [OP_W-1:0] CASE_3 = 4'd3;
  localparam logic [OP_W-1:0] CASE_4 = 4'd4;
  localparam logic [OP_W-1:0] CASE_5 = 4'd5;
  localparam logic [OP_W-1:0] CASE_6 = 4'd6;
  localparam logic [OP_W-1:0] CASE_7 = 4'd7;
  localparam logic [OP_W-1:0] CASE_8 = 4'd8;
  localparam logic [OP_W-1:0] CASE_9 = 4'd9;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_FOUR,
    CLS_CHAIN,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    cls_e     cls;
    logic     strict;
    val_t     p;
    val_t     x;
    val_t     y;
    val_t     z;
    val_t [3:0] ca;
    val_t [3:0] cb;
  } sel_t;

  typedef struct packed {
    cls_e              cls;
    logic              strict;
    logic [CODE_W-1:0] code;
    val_t              p;
    val_t              x;
    val_t              y;
    val_t              z;
    val_t              m3;
    val_t              mx;
    val_t              my;
    val_t              mz;
    val_t [3:0]        ca;
    val_t              ca_m3;
    val_t              ca_m2;
    val_t [3:0]        cb;
    val_t              cb_m3;
    val_t              cb_m2;
  } mins_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic              inner_unknown;
    logic              case_unknown;
    logic [CODE_W-1:0] order_code;
    logic              bad_case;
  } res_t;

  function automatic val_t vmask(logic [IN_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = {{(EXT_W-IN_W){1'b0}}, v};
    return e[VALUE_WIDTH-1:0];
  endfunction

  function automatic val_t vmin(val_t a, val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: rtl/lattice_subboundary_classifier.sv
// lattice_subboundary_classifier: three register stages (operand routing, minima, compare)
// a result word passes the select, minima and classify registers in turn; a stall can hold it in any of them
// throughput: one word per cycle while out_ready_i is high; every stage holds one word and refills as it drains
// reset: asynchronous active low, clears stage valid bits and the tolerance register to zero
// depends on lsc_pkg, lsc_select, lsc_minima, lsc_classify

module lattice_subboundary_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lsc_pkg::TOL_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lsc_pkg::OP_W-1:0]    operation_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_a_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_b_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_c_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_d_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_bc_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_ac_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]    len_ab_sq_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lsc_pkg::FLAG_W-1:0]  subcase_flags_o,
  output logic                        inner_unknown_o,
  output logic                        case_unknown_o,
  output logic [lsc_pkg::CODE_W-1:0]  order_code_o,
  output logic                        bad_case_o
);
  import lsc_pkg::*;

  logic [TOL_W-1:0] tol_q;
  logic             s1_valid, s1_ready, s2_valid, s2_ready;
  sel_t             s1_data;
  mins_t            s2_data;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  lsc_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .operation_i (operation_i),
    .len_a_sq_i  (len_a_sq_i),
    .len_b_sq_i  (len_b_sq_i),
    .len_c_sq_i  (len_c_sq_i),
    .len_d_sq_i  (len_d_sq_i),
    .len_bc_sq_i (len_bc_sq_i),
    .len_ac_sq_i (len_ac_sq_i),
    .len_ab_sq_i (len_ab_sq_i),
    .valid_o     (s1_valid),
    .ready_i     (s1_ready),
    .data_o      (s1_data)
  );

  lsc_minima u_minima (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  lsc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tolerance_i (tol_q),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .data_i      (s2_data),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (res)
  );

  assign subcase_flags_o = res.flags;
  assign inner_unknown_o = res.inner_unknown;
  assign case_unknown_o  = res.case_unknown;
  assign order_code_o    = res.order_code;
  assign bad_case_o      = res.bad_case;

endmodule

// File: rtl/lsc_select.sv
// lsc_select: first pipeline stage, decodes the case number and routes operands
// depends on lsc_pkg

module lsc_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [lsc_pkg::OP_W-1:0]  operation_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_a_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_b_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_c_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_d_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_bc_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_ac_sq_i,
  input  logic [lsc_pkg::IN_W-1:0]  len_ab_sq_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output lsc_pkg::sel_t             data_o
);
  import lsc_pkg::*;

  logic valid_q;
  sel_t data_q, data_d;
  val_t a, b, c, d, bc, ac, ab;

  assign a  = vmask(len_a_sq_i);
  assign b  = vmask(len_b_sq_i);
  assign c  = vmask(len_c_sq_i);
  assign d  = vmask(len_d_sq_i);
  assign bc = vmask(len_bc_sq_i);
  assign ac = vmask(len_ac_sq_i);
  assign ab = vmask(len_ab_sq_i);

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d        = '0;
    data_d.cls    = CLS_NONE;
    data_d.strict = 1'b0;
    unique case (operation_i) inside
      CASE_1, CASE_2, CASE_3: begin
        data_d.cls = CLS_NONE;
      end
      CASE_4: begin
        data_d.cls = CLS_FOUR;
        data_d.p = b; data_d.x = c; data_d.y = ac; data_d.z = ab;
        data_d.ca = {ab, c, b, ac};
        data_d.cb = {ac, c, b, ab};
      end
      CASE_5: begin
        data_d.cls = CLS_FOUR;
        data_d.strict = 1'b1;
        data_d.p = a; data_d.x = d; data_d.y = ac; data_d.z = ab;
        data_d.ca = {ab, d, a, ac};
        data_d.cb = {ac, d, a, ab};
      end
      CASE_6: begin
        data_d.cls = CLS_FOUR;
        data_d.p = a; data_d.x = c; data_d.y = bc; data_d.z = ab;
        data_d.ca = {ab, c, a, bc};
        data_d.cb = {bc, c, a, ab};
      end
      CASE_7: begin
        data_d.cls = CLS_CHAIN;
        data_d.p = b; data_d.x = d; data_d.y = bc; data_d.z = ab;
        data_d.ca = {d, bc, ab, b};
      end
      CASE_8: begin
        data_d.cls = CLS_FOUR;
        data_d.p = a; data_d.x = b; data_d.y = bc; data_d.z = ac;
        data_d.ca = {bc, b, a, ac};
        data_d.cb = {ac, b, a, bc};
      end
      CASE_9: begin
        data_d.cls = CLS_CHAIN;
        data_d.p = c; data_d.x = d; data_d.y = bc; data_d.z = ac;
        data_d.ca = {bc, d, ac, c};
      end
      default: begin
        data_d.cls = CLS_BAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/lsc_minima.sv
// lsc_minima: second pipeline stage, minima of two and three and the order code
// depends on lsc_pkg

module lsc_minima (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lsc_pkg::sel_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output lsc_pkg::mins_t data_o
);
  import lsc_pkg::*;

  logic  valid_q;
  mins_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.cls     = data_i.cls;
    data_d.strict  = data_i.strict;
    data_d.p       = data_i.p;
    data_d.x       = data_i.x;
    data_d.y       = data_i.y;
    data_d.z       = data_i.z;
    data_d.m3      = vmin(vmin(data_i.x, data_i.y), data_i.z);
    data_d.mx      = vmin(data_i.y, data_i.z);
    data_d.my      = vmin(data_i.z, data_i.x);
    data_d.mz      = vmin(data_i.x, data_i.y);
    data_d.code[0] = data_i.p <= data_i.x;
    data_d.code[1] = data_i.p <= data_i.y;
    data_d.code[2] = data_i.p <= data_i.z;
    data_d.code[3] = data_i.x <= data_i.y;
    data_d.code[4] = data_i.x <= data_i.z;
    data_d.code[5] = data_i.y <= data_i.z;
    data_d.ca      = data_i.ca;
    data_d.ca_m3   = vmin(vmin(data_i.ca[1], data_i.ca[2]), data_i.ca[3]);
    data_d.ca_m2   = vmin(data_i.ca[2], data_i.ca[3]);
    data_d.cb      = data_i.cb;
    data_d.cb_m3   = vmin(vmin(data_i.cb[1], data_i.cb[2]), data_i.cb[3]);
    data_d.cb_m2   = vmin(data_i.cb[2], data_i.cb[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("minima stage word changed under stall");
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.m3 <= data_q.mx && data_q.m3 <= data_q.my && data_q.m3 <= data_q.mz)
    else $error("min of three exceeds a min of two");
`endif

endmodule

// File: rtl/lsc_classify.sv
// lsc_classify: last pipeline stage, slack comparisons, subcase flags, result register
// depends on lsc_pkg

module lsc_classify (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lsc_pkg::TOL_W-1:0] tolerance_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  lsc_pkg::mins_t            data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output lsc_pkg::res_t             data_o
);
  import lsc_pkg::*;

  logic             valid_q;
  res_t             data_q, data_d;
  logic [CMP_W-1:0] dw;
  logic             inner, ch_a, ch_b;
  logic [5:0]       f, inner_f;

  assign dw      = CMP_W'(tolerance_i);
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // x - delta <= m
  function automatic logic le_sub(val_t v, val_t m, logic [CMP_W-1:0] t);
    return CMP_W'(v) <= (CMP_W'(m) + t);
  endfunction

  // x + delta >= m
  function automatic logic ge_add(val_t v, val_t m, logic [CMP_W-1:0] t);
    return (CMP_W'(v) + t) >= CMP_W'(m);
  endfunction

  function automatic logic lt_sub(val_t v, val_t m, logic [CMP_W-1:0] t);
    return CMP_W'(v) < (CMP_W'(m) + t);
  endfunction

  function automatic logic gt_add(val_t v, val_t m, logic [CMP_W-1:0] t);
    return (CMP_W'(v) + t) > CMP_W'(m);
  endfunction

  always_comb begin
    inner = le_sub(data_i.p, data_i.m3, dw);
    f[0]  = le_sub(data_i.x, data_i.mx, dw);
    f[1]  = ge_add(data_i.x, data_i.mx, dw);
    f[2]  = le_sub(data_i.y, data_i.my, dw);
    f[3]  = ge_add(data_i.y, data_i.my, dw);
    f[4]  = data_i.strict ? lt_sub(data_i.z, data_i.mz, dw) : le_sub(data_i.z, data_i.mz, dw);
    f[5]  = data_i.strict ? gt_add(data_i.z, data_i.mz, dw) : ge_add(data_i.z, data_i.mz, dw);
    inner_f = inner ? f : 6'd0;
    ch_a  = le_sub(data_i.ca[0], data_i.ca_m3, dw) && le_sub(data_i.ca[1], data_i.ca_m2, dw)
            && le_sub(data_i.ca[2], data_i.ca[3], dw);
    ch_b  = le_sub(data_i.cb[0], data_i.cb_m3, dw) && le_sub(data_i.cb[1], data_i.cb_m2, dw)
            && le_sub(data_i.cb[2], data_i.cb[3], dw);

    data_d = '0;
    unique case (data_i.cls)
      CLS_FOUR: begin
        data_d.flags         = {ch_b, ch_a, inner_f};
        data_d.inner_unknown = inner && (inner_f == 6'd0);
        data_d.case_unknown  = ({ch_b, ch_a, inner_f} == '0) && !(inner && (inner_f == 6'd0));
        data_d.order_code    = data_i.code;
      end
      CLS_CHAIN: begin
        data_d.flags        = {{(FLAG_W-1){1'b0}}, ch_a};
        data_d.case_unknown = !ch_a;
        data_d.order_code   = data_i.code;
      end
      CLS_BAD: begin
        data_d.bad_case = 1'b1;
      end
      CLS_NONE: begin
        data_d = '0;
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

`ifndef ASSERT_OFF
  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.bad_case |-> data_q.flags == '0 && !data_q.inner_unknown
      && !data_q.case_unknown && data_q.order_code == '0)
    else $error("bad case word carries other fields");
  a_inner_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.inner_unknown |-> data_q.flags[5:0] == '0 && !data_q.case_unknown)
    else $error("inner unknown with inner flags set");
  a_case_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.case_unknown |-> data_q.flags == '0 && !data_q.bad_case)
    else $error("case unknown with flags set");
`endif

endmodule
